// ===== rtl/fixed_point_sin_cos_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_SIN_COS_CORE_DEFINES_SVH
`define FIXED_POINT_SIN_COS_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define SC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sc_pkg.sv =====
`default_nettype none
package sc_pkg;

  localparam int unsigned TABLE_ENTRIES = 52;
  localparam int unsigned RED_STAGES    = 8;
  localparam int unsigned RED_GROUP     = 4;

  localparam logic [31:0] PI_Q29    = 32'h6487ED51;
  localparam logic [31:0] PI_Q30    = 32'hC90FDAA2;
  localparam logic [31:0] THIRD_Q31 = 32'h2AAAAAAB;
  localparam logic [4:0]  FB_MIN    = 5'd1;
  localparam logic [4:0]  FB_MAX    = 5'd29;

  typedef enum logic [1:0] {
    CFG_FRACTION_BITS = 2'd0,
    CFG_ANGLE_UNIT    = 2'd1
  } cfg_idx_e;

  // Item state carried through the reduction pipeline
  typedef struct packed {
    logic [31:0] r;
    logic [4:0]  steps;
    logic        neg;
    logic        cos;
    logic        unit;
    logic [4:0]  fb;
  } red_t;

  localparam logic [31:0] SIN_TAB [TABLE_ENTRIES] = '{
    32'd0,          32'd33553067,   32'd67097942,   32'd100626436,
    32'd134130364,  32'd167601545,  32'd201031810,  32'd234412995,
    32'd267736951,  32'd300995544,  32'd334180652,  32'd367284176,
    32'd400298032,  32'd433214161,  32'd466024527,  32'd498721120,
    32'd531295957,  32'd563741086,  32'd596048586,  32'd628210568,
    32'd660219183,  32'd692066614,  32'd723745087,  32'd755246868,
    32'd786564267,  32'd817689637,  32'd848615380,  32'd879333946,
    32'd909837834,  32'd940119599,  32'd970171848,  32'd999987242,
    32'd1029558505, 32'd1058878415, 32'd1087939815, 32'd1116735610,
    32'd1145258771, 32'd1173502333, 32'd1201459401, 32'd1229123150,
    32'd1256486826, 32'd1283543749, 32'd1310287313, 32'd1336710990,
    32'd1362808327, 32'd1388572955, 32'd1413998582, 32'd1439079002,
    32'd1463808091, 32'd1488179813, 32'd1512188216, 32'd1535827441
  };

  localparam logic [31:0] COS_TAB [TABLE_ENTRIES] = '{
    32'd2147483647, 32'd2147221509, 32'd2146435157, 32'd2145124784,
    32'd2143290709, 32'd2140933381, 32'd2138053374, 32'd2134651392,
    32'd2130728266, 32'd2126284953, 32'd2121322538, 32'd2115842232,
    32'd2109845374, 32'd2103333428, 32'd2096307983, 32'd2088770754,
    32'd2080723582, 32'd2072168431, 32'd2063107390, 32'd2053542671,
    32'd2043476608, 32'd2032911661, 32'd2021850407, 32'd2010295547,
    32'd1998249902, 32'd1985716414, 32'd1972698141, 32'd1959198262,
    32'd1945220073, 32'd1930766987, 32'd1915842531, 32'd1900450350,
    32'd1884594201, 32'd1868277956, 32'd1851505597, 32'd1834281220,
    32'd1816609030, 32'd1798493340, 32'd1779938574, 32'd1760949261,
    32'd1741530038, 32'd1721685646, 32'd1701420928, 32'd1680740833,
    32'd1659650409, 32'd1638154806, 32'd1616259270, 32'd1593969148,
    32'd1571289881, 32'd1548227007, 32'd1524786154, 32'd1500973048
  };

endpackage
`default_nettype wire

// ===== rtl/sc_intf.sv =====
`default_nettype none
interface sc_angle_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle;
  logic        operation;
  modport source (output valid, angle, operation, input ready);
  modport sink   (input valid, angle, operation, output ready);
endinterface

interface sc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface sc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sc_reduce.sv =====
`default_nettype none
module sc_reduce import sc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        in_valid_i,
  input  logic [31:0] angle_i,
  input  logic        op_i,
  input  logic [4:0]  fb_i,
  input  logic        unit_i,
  output logic        out_valid_o,
  output red_t        out_o
);

  // Run one group of conditional subtract-and-shift steps
  function automatic red_t step_group(red_t x, int unsigned base);
    logic [31:0] r;
    red_t        y;
    y = x;
    r = x.r;
    for (int unsigned k = 0; k < RED_GROUP; k++) begin
      if (5'(base + k) < x.steps) begin
        if (r >= PI_Q29) r = r - PI_Q29;
        r = {r[30:0], 1'b0};
      end
    end
    y.r = r;
    return y;
  endfunction

  logic [RED_STAGES-1:0] vld_q;
  red_t                  st_q [RED_STAGES];
  red_t                  st_d [RED_STAGES];
  red_t                  st0_d;
  logic [4:0]            fbc;
  logic [31:0]           mag;
  logic [31:0]           turn;
  logic                  neg0;
  logic [63:0]           turn_prod;

  // Fold the sign, clamp the format, wrap turns to a half turn
  always_comb begin
    if (fb_i < FB_MIN) fbc = FB_MIN;
    else if (fb_i > FB_MAX) fbc = FB_MAX;
    else fbc = fb_i;
    mag  = angle_i[31] ? (32'd0 - angle_i) : angle_i;
    neg0 = angle_i[31] & ~op_i;
    turn = mag << (6'd32 - {1'b0, fbc});
    if (turn[31]) begin
      turn[31] = 1'b0;
      if (unit_i) neg0 = ~neg0;
    end
    st0_d.r     = unit_i ? turn : mag;
    st0_d.steps = unit_i ? 5'd0 : (FB_MAX - fbc);
    st0_d.neg   = neg0;
    st0_d.cos   = op_i;
    st0_d.unit  = unit_i;
    st0_d.fb    = fbc;
  end

  // Turns scale by pi here; radians start the modulo-pi steps
  assign turn_prod = 64'(st_q[0].r) * 64'(PI_Q30);

  always_comb begin
    st_d[0] = st0_d;
    st_d[1] = step_group(st_q[0], 0);
    if (st_q[0].unit) st_d[1].r = turn_prod[62:31];
    for (int unsigned i = 2; i < RED_STAGES; i++) begin
      st_d[i] = step_group(st_q[i-1], RED_GROUP * (i - 1));
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[RED_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int unsigned i = 0; i < RED_STAGES; i++) st_q[i] <= st_d[i];
    end
  end

  assign out_valid_o = vld_q[RED_STAGES-1];
  assign out_o       = st_q[RED_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/sc_eval.sv =====
`default_nettype none
module sc_eval import sc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        in_valid_i,
  input  red_t        in_i,
  output logic        out_valid_o,
  output logic [31:0] value_o
);

  typedef struct packed {
    logic       neg;
    logic [4:0] fb;
  } ctl_t;

  logic [7:0] vld_q;

  // Stage A: last radian reduction step
  logic [31:0] a30_a_d, a30_a_q;
  logic        neg_a_d;
  logic        cos_a_q;
  ctl_t        ctl_a_q;
  always_comb begin
    logic [31:0] r;
    r       = in_i.r;
    neg_a_d = in_i.neg;
    if (!in_i.unit && r >= PI_Q29) begin
      r       = r - PI_Q29;
      neg_a_d = ~neg_a_d;
    end
    a30_a_d = in_i.unit ? r : {r[30:0], 1'b0};
  end

  // Stage B: fold to a quarter turn
  logic [31:0] a30_b_d, a30_b_q;
  logic        cos_b_q;
  ctl_t        ctl_b_d, ctl_b_q;
  always_comb begin
    a30_b_d = a30_a_q;
    ctl_b_d = ctl_a_q;
    if (a30_a_q >= PI_Q29) begin
      a30_b_d = PI_Q30 - a30_a_q;
      if (cos_a_q) ctl_b_d.neg = ~ctl_a_q.neg;
    end
  end

  // Stage C: fold to an octant and fetch the table pair
  logic [31:0] a31, arg;
  logic        swap;
  logic [5:0]  idx;
  logic [31:0] sv_c_q, cv_c_q;
  logic [24:0] h_c_q;
  logic        sin_c_q;
  ctl_t        ctl_c_q;
  always_comb begin
    a31  = {a30_b_q[30:0], 1'b0};
    swap = a31 > PI_Q29;
    arg  = swap ? (PI_Q30 - a31) : a31;
    idx  = arg[30:25];
    if (idx >= 6'(TABLE_ENTRIES)) idx = 6'(TABLE_ENTRIES - 1);
  end

  // Stage D: h / 3
  logic [56:0] t_prod;
  logic [23:0] t_d_q;
  logic [31:0] sv_d_q, cv_d_q;
  logic [24:0] h_d_q;
  logic        sin_d_q;
  ctl_t        ctl_d_q;
  assign t_prod = 57'(h_c_q) * 57'(THIRD_Q31);

  // Stage E: table value times h / 3
  logic [55:0] e_prod;
  logic [23:0] acc2_e_q;
  logic [31:0] sv_e_q, cv_e_q;
  logic [24:0] h_e_q;
  logic        sin_e_q;
  ctl_t        ctl_e_q;
  assign e_prod = 56'(sin_d_q ? cv_d_q : sv_d_q) * 56'(t_d_q);

  // Stage F: second-order term
  logic signed [33:0] acc3, acc4;
  logic signed [59:0] f_prod;
  logic signed [33:0] acc5_f_q;
  logic [31:0]        sv_f_q, cv_f_q;
  logic [24:0]        h_f_q;
  logic               sin_f_q;
  ctl_t               ctl_f_q;
  always_comb begin
    if (sin_e_q) acc3 = -($signed({2'b00, sv_e_q}) + $signed({10'd0, acc2_e_q}));
    else acc3 = $signed({10'd0, acc2_e_q}) - $signed({2'b00, cv_e_q});
    acc4   = acc3 >>> 1;
    f_prod = $signed({1'b0, h_e_q}) * acc4;
  end

  // Stage G: first-order term
  logic signed [33:0] acc6;
  logic signed [59:0] g_prod;
  logic signed [33:0] acc7_g_q;
  logic [31:0]        base_g_q;
  ctl_t               ctl_g_q;
  always_comb begin
    if (sin_f_q) acc6 = $signed({2'b00, cv_f_q}) + acc5_f_q;
    else acc6 = acc5_f_q - $signed({2'b00, sv_f_q});
    g_prod = $signed({1'b0, h_f_q}) * acc6;
  end

  // Stage H: sum, scale to the output format, apply sign
  logic signed [33:0] q;
  logic [31:0]        mag_out, value_d, value_q;
  always_comb begin
    q       = $signed({2'b00, base_g_q}) + acc7_g_q;
    mag_out = q[31:0] >> (5'd31 - ctl_g_q.fb);
    value_d = ctl_g_q.neg ? (32'd0 - mag_out) : mag_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a30_a_q  <= a30_a_d;
      cos_a_q  <= in_i.cos;
      ctl_a_q  <= '{neg: neg_a_d, fb: in_i.fb};
      a30_b_q  <= a30_b_d;
      cos_b_q  <= cos_a_q;
      ctl_b_q  <= ctl_b_d;
      sv_c_q   <= SIN_TAB[idx];
      cv_c_q   <= COS_TAB[idx];
      h_c_q    <= arg[24:0];
      sin_c_q  <= (cos_b_q == swap);
      ctl_c_q  <= ctl_b_q;
      t_d_q    <= t_prod[54:31];
      sv_d_q   <= sv_c_q;
      cv_d_q   <= cv_c_q;
      h_d_q    <= h_c_q;
      sin_d_q  <= sin_c_q;
      ctl_d_q  <= ctl_c_q;
      acc2_e_q <= e_prod[54:31];
      sv_e_q   <= sv_d_q;
      cv_e_q   <= cv_d_q;
      h_e_q    <= h_d_q;
      sin_e_q  <= sin_d_q;
      ctl_e_q  <= ctl_d_q;
      acc5_f_q <= 34'(f_prod >>> 31);
      sv_f_q   <= sv_e_q;
      cv_f_q   <= cv_e_q;
      h_f_q    <= h_e_q;
      sin_f_q  <= sin_e_q;
      ctl_f_q  <= ctl_e_q;
      acc7_g_q <= 34'(g_prod >>> 31);
      base_g_q <= sin_f_q ? sv_f_q : cv_f_q;
      ctl_g_q  <= ctl_f_q;
      value_q  <= value_d;
    end
  end

  assign out_valid_o = vld_q[7];
  assign value_o     = value_q;

endmodule
`default_nettype wire

// ===== rtl/fixed_point_sin_cos_core.sv =====
// Throughput: one angle per cycle unless the output stalls; the 8-stage
// reduction pipeline and 8-stage table/Taylor pipeline both advance
// together under one enable.
// Reset: asynchronous, active low; clears all valid bits and sets
// fraction_bits to 24 and angle_unit to radians.
`default_nettype none
module fixed_point_sin_cos_core import sc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sc_angle_if.sink   in_i,
  sc_result_if.source out_o,
  sc_cfg_if.sink     cfg_i
);

  logic [4:0] fb_q;
  logic       unit_q;
  logic       adv;
  logic       red_valid;
  red_t       red;
  logic       out_valid;

  // Hold configuration; writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q   <= 5'd24;
      unit_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FRACTION_BITS: fb_q   <= cfg_i.data[4:0];
        CFG_ANGLE_UNIT:    unit_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds a stalled result
  assign adv        = ~out_valid | out_o.ready;
  assign in_i.ready = adv;

  sc_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_i.valid),
    .angle_i     (in_i.angle),
    .op_i        (in_i.operation),
    .fb_i        (fb_q),
    .unit_i      (unit_q),
    .out_valid_o (red_valid),
    .out_o       (red)
  );

  sc_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (red_valid),
    .in_i        (red),
    .out_valid_o (out_valid),
    .value_o     (out_o.value)
  );

  assign out_o.valid = out_valid;

endmodule
`default_nettype wire

// ===== rtl/sc_checker.sv =====
`default_nettype none
`include "fixed_point_sin_cos_core_defines.svh"
module sc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_value_i
);

  `SC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "result valid in reset")
  `SC_ASSERT(a_ready_follows_out, clk_i, rst_ni, in_ready_i == (!out_valid_i || out_ready_i), "input ready does not track output stall")
  `SC_ASSERT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `SC_ASSERT(a_hold_value, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_value_i), "result changed while stalled")

endmodule

bind fixed_point_sin_cos_core sc_checker u_sc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value)
);
`default_nettype wire

// ===== sim/tb_fixed_point_sin_cos_core.sv =====
`default_nettype none
module tb_fixed_point_sin_cos_core;
  import sc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sc_angle_if  angle_ch ();
  sc_result_if result_ch ();
  sc_cfg_if    cfg_ch ();

  fixed_point_sin_cos_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (angle_ch),
    .out_o (result_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor's copy of the configuration
  logic [4:0] fb_reg;
  logic       turn_mode;

  // Expected values in arrival order; known marks a value typed into the table
  logic [31:0] value_queue [$];
  int          errors;
  int          mismatches;
  int          stall_left;
  bit          quiet_tail;
  bit          hold_off;

  typedef struct {
    logic [31:0] angle;
    logic        op;
    logic [4:0]  fb;
    logic        unit;
    bit          known;
    logic [31:0] value;
  } vector_t;

  // floor(a * b / 2^31)
  function automatic longint q31_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 31;
  endfunction

  function automatic longint taylor_eval(logic [31:0] arg, bit want_cos);
    int unsigned idx;
    longint sv, cv, h, acc;
    idx = (arg >> 25) & 32'h3F;
    if (idx >= TABLE_ENTRIES) idx = TABLE_ENTRIES - 1;
    sv = longint'(SIN_TAB[idx]);
    cv = longint'(COS_TAB[idx]);
    h = longint'(arg & 32'h01FFFFFF);
    acc = q31_mul(longint'(THIRD_Q31), h);
    if (!want_cos) begin
      acc = q31_mul(cv, acc);
      acc = -(sv + acc);
      acc = acc >>> 1;
      acc = q31_mul(h, acc);
      acc = cv + acc;
      acc = q31_mul(h, acc);
      return sv + acc;
    end else begin
      acc = q31_mul(sv, acc);
      acc = acc - cv;
      acc = acc >>> 1;
      acc = q31_mul(h, acc);
      acc = acc - sv;
      acc = q31_mul(h, acc);
      return cv + acc;
    end
  endfunction

  function automatic logic [31:0] trig_value(logic [31:0] raw, logic want_cos);
    logic [4:0] fb;
    logic [31:0] mag, a30, a31, turn, r, out;
    logic [63:0] prod;
    bit neg;
    longint q;
    fb = fb_reg;
    neg = 0;
    if (fb < FB_MIN) fb = FB_MIN;
    if (fb > FB_MAX) fb = FB_MAX;
    mag = raw;
    if (raw[31]) begin
      mag = -raw;
      if (!want_cos) neg = 1;
    end
    if (turn_mode) begin
      turn = mag << (32 - fb);
      if (turn >= 32'h80000000) begin
        turn -= 32'h80000000;
        neg = !neg;
      end
      prod = 64'(turn) * 64'(PI_Q30);
      a30 = prod[62:31];
    end else begin
      r = mag;
      for (int s = 29 - fb; s > 0; s--) begin
        if (r >= PI_Q29) r -= PI_Q29;
        r = r << 1;
      end
      if (r >= PI_Q29) begin
        r -= PI_Q29;
        neg = !neg;
      end
      a30 = r << 1;
    end
    if (a30 >= PI_Q29) begin
      a30 = PI_Q30 - a30;
      if (want_cos) neg = !neg;
    end
    a31 = a30 << 1;
    if (a31 > PI_Q29) q = taylor_eval(PI_Q30 - a31, !want_cos);
    else q = taylor_eval(a31, want_cos);
    out = 32'(q) >> (31 - fb);
    if (neg) out = -out;
    return out;
  endfunction

  // Write one register; block must be idle
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_FRACTION_BITS) fb_reg = data[4:0];
    else turn_mode = data[0];
  endtask

  // Wait for every expected value, then let the pipeline drain
  task automatic drain();
    while (value_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reconfigure(logic [4:0] fb, logic unit);
    drain();
    write_reg(CFG_FRACTION_BITS, {27'h5A5A5A5 ^ 27'(fb), fb});
    write_reg(CFG_ANGLE_UNIT, {31'(unit), unit});
  endtask

  // Offer one angle, sometimes after a random gap, and record its expected value
  task automatic send_angle(logic [31:0] ang, logic op, bit known, logic [31:0] val);
    logic [31:0] pred;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    angle_ch.angle     <= ang;
    angle_ch.operation <= op;
    angle_ch.valid     <= 1'b1;
    do @(posedge clk_i); while (!angle_ch.ready);
    pred = trig_value(ang, op);
    if (known && pred !== val) begin
      errors++;
      if (mismatches++ < 10)
        $display("table row mismatch angle=%h op=%0d table=%h predicted=%h",
                 ang, op, val, pred);
    end
    value_queue.push_back(pred);
  endtask

  task automatic release_input();
    angle_ch.valid <= 1'b0;
  endtask

  // Result side: random stall bursts, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off) begin
      result_ch.ready <= 1'b0;
    end else if (quiet_tail) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (value_queue.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", result_ch.value);
      end else begin
        logic [31:0] want;
        want = value_queue.pop_front();
        if (result_ch.value !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("value mismatch: expected %h actual %h", want, result_ch.value);
        end
      end
    end
  end

  // Random angle biased toward edges
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return $urandom_range(0, 64);
      3: return -$urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  vector_t directed [] = '{
    '{32'h00000000, 1'b0, 5'd24, 1'b0, 1, 32'h00000000},
    '{32'h00000000, 1'b1, 5'd24, 1'b0, 1, 32'h00FFFFFF},
    '{32'h7FFFFFFF, 1'b0, 5'd24, 1'b0, 0, 0},
    '{32'h80000000, 1'b0, 5'd24, 1'b0, 0, 0},
    '{32'h80000000, 1'b1, 5'd24, 1'b0, 0, 0},
    '{32'h00000001, 1'b1, 5'd24, 1'b0, 0, 0},
    '{32'hFFFFFFFF, 1'b0, 5'd24, 1'b0, 0, 0},
    '{32'h00000000, 1'b1, 5'd1,  1'b0, 0, 0},
    '{32'h7FFFFFFF, 1'b0, 5'd1,  1'b0, 0, 0},
    '{32'h80000000, 1'b1, 5'd1,  1'b0, 0, 0},
    '{32'h12345678, 1'b0, 5'd29, 1'b0, 0, 0},
    '{32'h80000000, 1'b0, 5'd29, 1'b0, 0, 0},
    '{32'h0000002A, 1'b0, 5'd0,  1'b0, 0, 0},
    '{32'h3FFFFFFF, 1'b1, 5'd31, 1'b0, 0, 0},
    '{32'h55555555, 1'b0, 5'd30, 1'b1, 0, 0},
    '{32'h00000000, 1'b0, 5'd16, 1'b1, 1, 32'h00000000},
    '{32'h00004000, 1'b0, 5'd16, 1'b1, 0, 0},
    '{32'h00008000, 1'b1, 5'd16, 1'b1, 0, 0},
    '{32'hFFFFC000, 1'b0, 5'd16, 1'b1, 0, 0},
    '{32'h80000000, 1'b0, 5'd16, 1'b1, 0, 0},
    '{32'h7FFFFFFF, 1'b1, 5'd1,  1'b1, 0, 0},
    '{32'h00000001, 1'b0, 5'd29, 1'b1, 0, 0},
    '{32'h80000001, 1'b1, 5'd29, 1'b1, 0, 0}
  };

  // Stimulus
  initial begin
    logic [4:0] cur_fb;
    logic       cur_unit;
    angle_ch.valid     <= 1'b0;
    angle_ch.angle     <= '0;
    angle_ch.operation <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_FRACTION_BITS;
    cfg_ch.data        <= '0;
    fb_reg = 5'd24;
    turn_mode = 1'b0;
    errors = 0;
    mismatches = 0;
    quiet_tail = 0;
    hold_off = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cur_fb = 5'd24;
    cur_unit = 1'b0;

    // Directed table
    foreach (directed[i]) begin
      if (directed[i].fb != cur_fb || directed[i].unit != cur_unit) begin
        release_input();
        cur_fb = directed[i].fb;
        cur_unit = directed[i].unit;
        reconfigure(cur_fb, cur_unit);
      end
      send_angle(directed[i].angle, directed[i].op, directed[i].known, directed[i].value);
    end
    release_input();

    // Random phases across settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: reconfigure(5'd1, 1'b0);
        1: reconfigure(5'd29, 1'b1);
        default: reconfigure(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      endcase
      if (ph == 2) begin
        // Stall output while input keeps offering
        hold_off = 1;
        fork
          begin
            repeat (60) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      if (ph == 9) quiet_tail = 1;
      for (int k = 0; k < 123; k++)
        send_angle(pick_angle(), 1'($urandom_range(0, 1)), 0, '0);
      release_input();
      if (ph == 5) drain();
    end
    drain();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== fixed_point_sin_cos_core.f =====
+incdir+rtl
rtl/sc_pkg.sv
rtl/sc_intf.sv
rtl/sc_reduce.sv
rtl/sc_eval.sv
rtl/fixed_point_sin_cos_core.sv
rtl/sc_checker.sv
sim/tb_fixed_point_sin_cos_core.sv
